>>> src/dtbs_pkg.sv
// ----------------------------------------------------------------------------
// dtbs_pkg
// shared types and constants of the two-bit squash encoder
// ----------------------------------------------------------------------------
`default_nettype none

package dtbs_pkg;

	// request codes on req_type
	localparam logic [1:0] REQ_CHAR   = 2'd0;
	localparam logic [1:0] REQ_CONTIG = 2'd1;
	localparam logic [1:0] REQ_EOS    = 2'd2;

	// result codes on out_kind
	localparam logic [1:0] KIND_WORD   = 2'd0;
	localparam logic [1:0] KIND_REGION = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// packing geometry
	localparam int BASES_PER_WORD = 16;
	localparam int BPW_LOG2       = $clog2(BASES_PER_WORD);
	localparam int WORD_BITS      = 32;
	localparam int CODE_BITS      = 2;

	// result field widths
	localparam int OUT_POS_BITS = 40;
	localparam int OUT_END_BITS = 41;

	// configuration port
	localparam int         APB_ADDR_BITS  = 2;
	localparam int         APB_DATA_BITS  = 32;
	localparam logic [1:0] REG_ALLOW_ADDR = 2'd0;

	// work handed from the front to the back
	typedef enum logic [2:0] {
		OP_BASE,
		OP_NONBASE,
		OP_BOUNDARY,
		OP_EOS,
		OP_ERROR
	} op_kind_t;

	typedef struct packed {
		op_kind_t              kind;
		logic [CODE_BITS-1:0]  code;
	} op_t;

	// one result beat
	typedef struct packed {
		logic [1:0]                    kind;
		logic [WORD_BITS-1:0]          word;
		logic [OUT_POS_BITS-1:0]       rbegin;
		logic signed [OUT_END_BITS-1:0] rend;
		logic [OUT_POS_BITS-1:0]       total;
		logic                          last;
	} res_t;

endpackage

`default_nettype wire

>>> src/dna_two_bit_squash_encoder_core.sv
// ----------------------------------------------------------------------------
// dna_two_bit_squash_encoder_core
// packs sequence characters into two-bit base words and reports valid regions
// ----------------------------------------------------------------------------
//
// channel   direction  handshake          beat
// input     in         push / full        req_type, char_byte
// result    out        pop / empty        out_kind, packed_word, region_begin,
//                                         region_end, valid_total, last_of_run
// config    in/out     psel/penable/...   allow_many_contigs at byte 0
//
// one input beat is taken every cycle while full is low; a result reaches the
// result ports through the work queue and then the result queue, and can be
// popped from there
// a beat giving two results writes both in one cycle; the result side drains
// one beat per cycle while pop is high and so sets the sustained rate
// whitespace and beats after a halt give no result and cost nothing downstream
// asynchronous reset clears position, run state, counts, halt and both queues
// full rises only when the work queue is full; empty/pop stall the back alone
//
`default_nettype none

module dna_two_bit_squash_encoder_core
	import dtbs_pkg::*;
#(
	parameter int POS_BITS = 40
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,

	// input queue side
	input  wire logic                     push,
	output logic                          full,
	input  wire logic [1:0]               req_type,
	input  wire logic [7:0]               char_byte,

	// result queue side
	output logic                          empty,
	input  wire logic                     pop,
	output logic [1:0]                    out_kind,
	output logic [WORD_BITS-1:0]          packed_word,
	output logic [OUT_POS_BITS-1:0]       region_begin,
	output logic signed [OUT_END_BITS-1:0] region_end,
	output logic [OUT_POS_BITS-1:0]       valid_total,
	output logic                          last_of_run,

	// configuration port
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [APB_ADDR_BITS-1:0] paddr,
	input  wire logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0]      prdata,
	output logic                          pready
);

	logic allow_q;   // allow_many_contigs
	logic op_full;
	logic op_push;
	op_t  op_in;
	logic op_valid;
	logic op_pop;
	op_t  op_out;
	res_t res;

	// config register, written in the access phase
	assign pready = 1'b1;
	assign prdata = (paddr == REG_ALLOW_ADDR) ? APB_DATA_BITS'(allow_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && paddr == REG_ALLOW_ADDR) begin
			allow_q <= pwdata[0];
		end
	end

	// front: accept, skip whitespace, decode, boundary check and halt
	dtbs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.req_type   (req_type),
		.char_byte  (char_byte),
		.allow_many (allow_q),
		.op_full    (op_full),
		.op_push    (op_push),
		.op         (op_in)
	);

	// short work queue so front and back stall on their own
	dtbs_opq u_opq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (op_push),
		.din    (op_in),
		.full   (op_full),
		.valid  (op_valid),
		.pop    (op_pop),
		.dout   (op_out)
	);

	// back: positions, packing, regions and the result queue
	dtbs_back #(
		.POS_BITS (POS_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op       (op_out),
		.op_pop   (op_pop),
		.empty    (empty),
		.pop      (pop),
		.res      (res)
	);

	// result beat fields
	assign out_kind     = res.kind;
	assign packed_word  = res.word;
	assign region_begin = res.rbegin;
	assign region_end   = res.rend;
	assign valid_total  = res.total;
	assign last_of_run  = res.last;

endmodule

`default_nettype wire

>>> src/dtbs_front.sv
// ----------------------------------------------------------------------------
// dtbs_front
// accepts input beats, drops whitespace, decodes bases, checks boundaries
// ----------------------------------------------------------------------------
`default_nettype none

module dtbs_front
	import dtbs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [1:0] req_type,
	input  wire logic [7:0] char_byte,
	input  wire logic       allow_many,
	input  wire logic       op_full,
	output logic            op_push,
	output op_t             op
);

	logic halted_q;
	logic accept;
	logic keep;
	logic set_halt;

	// space, tab, newline, vertical tab, form feed, carriage return
	function automatic logic is_space(input logic [7:0] c);
		return (c inside {8'h20, [8'h09:8'h0d]});
	endfunction

	function automatic logic is_base(input logic [7:0] c);
		return (c inside {"A", "a", "C", "c", "G", "g", "T", "t"});
	endfunction

	function automatic logic [CODE_BITS-1:0] base_code(input logic [7:0] c);
		logic [CODE_BITS-1:0] r;
		case (c)
			"C", "c": r = 2'd1;
			"G", "g": r = 2'd2;
			"T", "t": r = 2'd3;
			default:  r = 2'd0;
		endcase
		return r;
	endfunction

	assign full    = op_full;
	assign accept  = push && !op_full;
	assign op_push = accept && keep && !halted_q;

	always_comb begin
		keep     = 1'b0;
		set_halt = 1'b0;
		op.kind  = OP_BASE;
		op.code  = '0;
		case (req_type)
			REQ_CHAR: begin
				keep    = !is_space(char_byte);
				op.kind = is_base(char_byte) ? OP_BASE : OP_NONBASE;
				op.code = base_code(char_byte);
			end
			REQ_CONTIG: begin
				keep     = 1'b1;
				op.kind  = allow_many ? OP_BOUNDARY : OP_ERROR;
				set_halt = !allow_many;
			end
			REQ_EOS: begin
				keep    = 1'b1;
				op.kind = OP_EOS;
			end
			default: keep = 1'b0;
		endcase
	end

	// halt holds until reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q <= 1'b0;
		end else if (op_push && set_halt) begin
			halted_q <= 1'b1;
		end
	end

endmodule

`default_nettype wire

>>> src/dtbs_opq.sv
// ----------------------------------------------------------------------------
// dtbs_opq
// two-entry queue of decoded work between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module dtbs_opq
	import dtbs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  op_t       din,
	output logic      full,
	output logic      valid,
	input  wire logic pop,
	output op_t       dout
);

	op_t        mem_q [2];
	logic       head_q;
	logic       tail_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full    = (cnt_q == 2'd2);
	assign valid   = (cnt_q != 2'd0);
	assign dout    = mem_q[head_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[tail_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= 1'b0;
			tail_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (do_push) begin
				tail_q <= !tail_q;
			end
			if (do_pop) begin
				head_q <= !head_q;
			end
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

`default_nettype wire

>>> src/dtbs_back.sv
// ----------------------------------------------------------------------------
// dtbs_back
// position and run tracking, word packing, region records, result queue
// ----------------------------------------------------------------------------
`default_nettype none

module dtbs_back
	import dtbs_pkg::*;
#(
	parameter int POS_BITS = 40
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic op_valid,
	input  op_t       op,
	output logic      op_pop,
	output logic      empty,
	input  wire logic pop,
	output res_t      res
);

	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR   = $clog2(RQ_DEPTH);
	localparam int RQ_CNT   = RQ_PTR + 1;

	// encoder state
	logic [POS_BITS-1:0]  pos_q;
	logic [WORD_BITS-1:0] accum_q;
	logic                 in_run_q;
	logic [POS_BITS-1:0]  run_begin_q;
	logic [POS_BITS-1:0]  run_len_q;
	logic [POS_BITS-1:0]  vcount_q;

	// result queue
	res_t              rq_q [RQ_DEPTH];
	logic [RQ_PTR-1:0] head_q;
	logic [RQ_PTR-1:0] tail_q;
	logic [RQ_CNT-1:0] cnt_q;
	logic              out_pop;

	logic [POS_BITS-1:0]     pos_inc;
	logic [WORD_BITS-1:0]    accum_shift;
	logic                    word_full;
	logic [POS_BITS-1:0]     vcount_sum;
	logic [BPW_LOG2-1:0]     fill;
	logic [BPW_LOG2:0]       fill_neg;
	logic [WORD_BITS-1:0]    pad_word;
	res_t                    region_rec;
	res_t                    word_rec;
	res_t                    pad_rec;
	res_t                    err_rec;
	res_t                    r0;
	res_t                    r1;
	logic [1:0]              n_res;

	// room for two results before taking work
	assign op_pop  = op_valid && (cnt_q <= RQ_CNT'(RQ_DEPTH - 2));
	assign empty   = (cnt_q == '0);
	assign out_pop = pop && !empty;
	assign res     = rq_q[head_q];

	always_comb begin
		pos_inc     = pos_q + 1'b1;
		accum_shift = {accum_q[WORD_BITS-CODE_BITS-1:0], op.code};
		if (op.kind == OP_NONBASE) begin
			accum_shift[CODE_BITS-1:0] = '0;
		end
		word_full  = (pos_inc[BPW_LOG2-1:0] == '0);
		vcount_sum = vcount_q + run_len_q;
		fill       = pos_q[BPW_LOG2-1:0];
		fill_neg   = (BPW_LOG2+1)'(BASES_PER_WORD) - {1'b0, fill};
		pad_word   = accum_q << {fill_neg[BPW_LOG2-1:0], 1'b0};

		// closes the open run, or an empty region at the current position
		region_rec        = '0;
		region_rec.kind   = KIND_REGION;
		region_rec.rbegin = in_run_q ? OUT_POS_BITS'(run_begin_q) : OUT_POS_BITS'(pos_q);
		region_rec.rend   = OUT_END_BITS'(pos_q) - OUT_END_BITS'(1);
		region_rec.total  = in_run_q ? OUT_POS_BITS'(vcount_sum) : OUT_POS_BITS'(vcount_q);

		word_rec       = '0;
		word_rec.kind  = KIND_WORD;
		word_rec.word  = accum_shift;
		word_rec.total = (op.kind == OP_NONBASE && in_run_q) ?
			OUT_POS_BITS'(vcount_sum) : OUT_POS_BITS'(vcount_q);

		pad_rec       = '0;
		pad_rec.kind  = KIND_WORD;
		pad_rec.word  = pad_word;
		pad_rec.total = OUT_POS_BITS'(vcount_q);

		err_rec      = '0;
		err_rec.kind = KIND_ERROR;

		r0    = word_rec;
		r1    = word_rec;
		n_res = 2'd0;
		case (op.kind)
			OP_BASE: begin
				n_res = word_full ? 2'd1 : 2'd0;
			end
			OP_NONBASE: begin
				if (in_run_q) begin
					r0    = region_rec;
					n_res = word_full ? 2'd2 : 2'd1;
				end else begin
					n_res = word_full ? 2'd1 : 2'd0;
				end
			end
			OP_BOUNDARY: begin
				r0    = region_rec;
				n_res = 2'd1;
			end
			OP_EOS: begin
				if (fill != '0) begin
					r0    = pad_rec;
					r1    = region_rec;
					n_res = 2'd2;
				end else begin
					r0    = region_rec;
					n_res = 2'd1;
				end
			end
			OP_ERROR: begin
				r0    = err_rec;
				n_res = 2'd1;
			end
			default: n_res = 2'd0;
		endcase
		r0.last = (n_res == 2'd1);
		r1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			accum_q     <= '0;
			in_run_q    <= 1'b0;
			run_begin_q <= '0;
			run_len_q   <= '0;
			vcount_q    <= '0;
		end else if (op_pop) begin
			case (op.kind)
				OP_BASE: begin
					if (!in_run_q) begin
						in_run_q    <= 1'b1;
						run_begin_q <= pos_q;
						run_len_q   <= POS_BITS'(1);
					end else begin
						run_len_q <= run_len_q + 1'b1;
					end
					pos_q   <= pos_inc;
					accum_q <= word_full ? '0 : accum_shift;
				end
				OP_NONBASE: begin
					if (in_run_q) begin
						in_run_q <= 1'b0;
						vcount_q <= vcount_sum;
					end
					pos_q   <= pos_inc;
					accum_q <= word_full ? '0 : accum_shift;
				end
				OP_BOUNDARY: begin
					if (in_run_q) begin
						in_run_q <= 1'b0;
						vcount_q <= vcount_sum;
					end
				end
				OP_EOS: begin
					pos_q       <= '0;
					accum_q     <= '0;
					in_run_q    <= 1'b0;
					run_begin_q <= '0;
					run_len_q   <= '0;
					vcount_q    <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// result queue, up to two writes a cycle
	always_ff @(posedge clk) begin
		if (op_pop && n_res != 2'd0) begin
			rq_q[tail_q] <= r0;
		end
		if (op_pop && n_res == 2'd2) begin
			rq_q[tail_q + 1'b1] <= r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (op_pop) begin
				tail_q <= tail_q + RQ_PTR'(n_res);
			end
			if (out_pop) begin
				head_q <= head_q + 1'b1;
			end
			cnt_q <= cnt_q + (op_pop ? RQ_CNT'(n_res) : '0) - RQ_CNT'(out_pop);
		end
	end

	// result queue never overflows
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= RQ_CNT'(RQ_DEPTH))
		else $error("result queue overflow");

	// work is only taken with room for two results
	assert property (@(posedge clk) disable iff (!arst_n)
		op_pop |-> (cnt_q <= RQ_CNT'(RQ_DEPTH - 2)))
		else $error("work taken without result room");

	// end of stream leaves the stream state cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		(op_pop && op.kind == OP_EOS) |=> (pos_q == '0 && !in_run_q && vcount_q == '0))
		else $error("stream state not cleared after end of stream");

	// a base that opens a run records the run as open with a length of one
	assert property (@(posedge clk) disable iff (!arst_n)
		(op_pop && op.kind == OP_BASE && !in_run_q) |=> (in_run_q && run_len_q == POS_BITS'(1)))
		else $error("run start not recorded");

endmodule

`default_nettype wire

>>> test/dtbs_core_checker.sv
// ----------------------------------------------------------------------------
// dtbs_core_checker
// watches the encoder's channels, predicts every result beat and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dtbs_core_checker
	import dtbs_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	input  wire logic                      full,
	input  wire logic [1:0]                req_type,
	input  wire logic [7:0]                char_byte,
	input  wire logic                      empty,
	input  wire logic                      pop,
	input  wire logic [1:0]                out_kind,
	input  wire logic [WORD_BITS-1:0]      packed_word,
	input  wire logic [OUT_POS_BITS-1:0]   region_begin,
	input  wire logic signed [OUT_END_BITS-1:0] region_end,
	input  wire logic [OUT_POS_BITS-1:0]   valid_total,
	input  wire logic                      last_of_run,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [APB_ADDR_BITS-1:0]  paddr,
	input  wire logic [APB_DATA_BITS-1:0]  pwdata,
	input  wire logic                      pready,
	output int                             fail_count,
	output int                             outstanding
);

	localparam logic [1:0] CODE_A = 2'd0;
	localparam logic [1:0] CODE_C = 2'd1;
	localparam logic [1:0] CODE_G = 2'd2;
	localparam logic [1:0] CODE_T = 2'd3;

	// own copy of the encoder state
	logic [OUT_POS_BITS-1:0] base_pos;
	logic [OUT_POS_BITS-1:0] run_start;
	logic [OUT_POS_BITS-1:0] valid_sum;
	logic [WORD_BITS-1:0]    code_accum;
	logic                    run_open;
	logic                    stopped;
	logic                    allow_contigs;

	res_t step_out [2];
	int   step_n;
	res_t awaited_records [$];

	int fails = 0;
	int waiting = 0;

	assign fail_count  = fails;
	assign outstanding = waiting;

	function automatic logic is_space(input logic [7:0] ch);
		return ch == 8'h20 || ch == 8'h09 || ch == 8'h0a || ch == 8'h0b ||
			ch == 8'h0c || ch == 8'h0d;
	endfunction

	function automatic logic [1:0] base_code(input logic [7:0] ch, output logic is_base);
		is_base = 1'b1;
		case (ch)
			"A", "a": return CODE_A;
			"C", "c": return CODE_C;
			"G", "g": return CODE_G;
			"T", "t": return CODE_T;
			default: begin
				is_base = 1'b0;
				return CODE_A;
			end
		endcase
	endfunction

	// last position of a region ending just before p; -1 when p is zero
	function automatic logic signed [OUT_END_BITS-1:0] region_last(
		input logic [OUT_POS_BITS-1:0] p);
		return {1'b0, p} - 1'b1;
	endfunction

	task automatic post_record(input logic [1:0] kind, input logic [WORD_BITS-1:0] word,
		input logic [OUT_POS_BITS-1:0] rbegin, input logic signed [OUT_END_BITS-1:0] rend,
		input logic [OUT_POS_BITS-1:0] total);
		res_t rec;
		rec.kind   = kind;
		rec.word   = word;
		rec.rbegin = rbegin;
		rec.rend   = rend;
		rec.total  = total;
		rec.last   = 1'b0;
		step_out[step_n] = rec;
		step_n++;
	endtask

	task automatic close_region();
		valid_sum = valid_sum + (base_pos - run_start);
		run_open  = 1'b0;
		post_record(KIND_REGION, '0, run_start, region_last(base_pos), valid_sum);
	endtask

	task automatic close_or_empty();
		if (run_open)
			close_region();
		else
			post_record(KIND_REGION, '0, base_pos, region_last(base_pos), valid_sum);
	endtask

	task automatic squash_encode(input logic [1:0] kind, input logic [7:0] ch);
		logic [1:0] code;
		logic       is_base;
		int         fill;
		step_n = 0;
		if (!stopped) begin
			case (kind)
				REQ_CHAR: begin
					if (!is_space(ch)) begin
						code = base_code(ch, is_base);
						if (is_base) begin
							if (!run_open) begin
								run_start = base_pos;
								run_open  = 1'b1;
							end
						end else if (run_open) begin
							close_region();
						end
						code_accum = {code_accum[WORD_BITS-CODE_BITS-1:0], code};
						base_pos   = base_pos + 1'b1;
						if (base_pos[BPW_LOG2-1:0] == '0) begin
							post_record(KIND_WORD, code_accum, '0, '0, valid_sum);
							code_accum = '0;
						end
					end
				end
				REQ_CONTIG: begin
					if (!allow_contigs) begin
						post_record(KIND_ERROR, '0, '0, '0, '0);
						stopped = 1'b1;
					end else begin
						close_or_empty();
					end
				end
				REQ_EOS: begin
					fill = int'(base_pos[BPW_LOG2-1:0]);
					if (fill != 0)
						post_record(KIND_WORD,
							code_accum << (CODE_BITS * (BASES_PER_WORD - fill)),
							'0, '0, valid_sum);
					close_or_empty();
					base_pos   = '0;
					code_accum = '0;
					run_open   = 1'b0;
					run_start  = '0;
					valid_sum  = '0;
				end
				default: ;
			endcase
		end
		if (step_n > 0)
			step_out[step_n-1].last = 1'b1;
		for (int k = 0; k < step_n; k++)
			awaited_records = {awaited_records, step_out[k]};
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			$error("%s expected %h actual %h", name, want, got);
			fails++;
		end
	endtask

	task automatic check_beat();
		res_t want;
		if (awaited_records.size() == 0) begin
			$error("result beat with nothing predicted, out_kind %0d", out_kind);
			fails++;
		end else begin
			want = awaited_records.pop_front();
			compare_field("out_kind", want.kind, out_kind);
			compare_field("packed_word", want.word, packed_word);
			compare_field("region_begin", want.rbegin, region_begin);
			compare_field("region_end", want.rend, region_end);
			compare_field("valid_total", want.total, valid_total);
			compare_field("last_of_run", want.last, last_of_run);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_pos      = '0;
			run_start     = '0;
			valid_sum     = '0;
			code_accum    = '0;
			run_open      = 1'b0;
			stopped       = 1'b0;
			allow_contigs = 1'b1;
			awaited_records.delete();
			waiting = 0;
		end else begin
			// results pass the work queue and then the result queue before they leave,
			// so the oldest prediction is never the one made at this same edge
			if (pop && !empty)
				check_beat();
			if (psel && penable && pwrite && pready && paddr == REG_ALLOW_ADDR)
				allow_contigs = pwdata[0];
			if (push && !full)
				squash_encode(req_type, char_byte);
			waiting = awaited_records.size();
		end
	end

endmodule

>>> test/tb_dna_two_bit_squash_encoder_core.sv
// ----------------------------------------------------------------------------
// tb_dna_two_bit_squash_encoder_core
// drives character streams, boundaries and end-of-stream beats into the
// encoder under changing idle patterns and contig settings; a checker beside
// the block predicts and compares every result beat
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_dna_two_bit_squash_encoder_core;
	import dtbs_pkg::*;

	localparam int HALF_PERIOD   = 10;
	localparam int RESET_CYCLES  = 7;
	localparam int STALL_LIMIT   = 5000;
	localparam int LONG_HOLD     = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS   = 350;
	localparam int HEAVY_ITEMS   = 150;

	// request code the block must ignore
	localparam logic [1:0] REQ_SPARE = 2'd3;

	// characters with a special meaning
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_VT    = 8'h0b;
	localparam logic [7:0] CH_FF    = 8'h0c;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_GT    = 8'h3e;

	logic                       clk;
	logic                       arst_n;
	logic                       push;
	logic                       full;
	logic [1:0]                 req_type;
	logic [7:0]                 char_byte;
	logic                       empty;
	logic                       pop;
	logic [1:0]                 out_kind;
	logic [WORD_BITS-1:0]       packed_word;
	logic [OUT_POS_BITS-1:0]    region_begin;
	logic signed [OUT_END_BITS-1:0] region_end;
	logic [OUT_POS_BITS-1:0]    valid_total;
	logic                       last_of_run;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [APB_ADDR_BITS-1:0]   paddr;
	logic [APB_DATA_BITS-1:0]   pwdata;
	logic [APB_DATA_BITS-1:0]   prdata;
	logic                       pready;

	int fail_count;
	int outstanding;

	// idle odds in percent, and the one-off long hold of the receiver
	int   feed_idle_pct;
	int   drain_idle_pct;
	logic long_hold_req;
	logic long_hold_done;

	dna_two_bit_squash_encoder_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.req_type     (req_type),
		.char_byte    (char_byte),
		.empty        (empty),
		.pop          (pop),
		.out_kind     (out_kind),
		.packed_word  (packed_word),
		.region_begin (region_begin),
		.region_end   (region_end),
		.valid_total  (valid_total),
		.last_of_run  (last_of_run),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	dtbs_core_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.req_type     (req_type),
		.char_byte    (char_byte),
		.empty        (empty),
		.pop          (pop),
		.out_kind     (out_kind),
		.packed_word  (packed_word),
		.region_begin (region_begin),
		.region_end   (region_end),
		.valid_total  (valid_total),
		.last_of_run  (last_of_run),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	// receiver: pops at random, with one long hold so the block backs up
	initial begin : receiver
		int hold_left;
		hold_left      = 0;
		long_hold_done = 1'b0;
		pop            = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req && !long_hold_done) begin
				hold_left      = LONG_HOLD;
				long_hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= drain_idle_pct);
			end
		end
	end

	// watchdog: too many cycles in a row with no beat on either side
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_dna_two_bit_squash_encoder_core failed");
		$finish;
	end

	// offer one input beat, with random idle cycles ahead of it
	task automatic offer_item(input logic [1:0] kind, input logic [7:0] ch);
		while ($urandom_range(99) < feed_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push      <= 1'b1;
		req_type  <= kind;
		char_byte <= ch;
		do @(posedge clk); while (full);
	endtask

	// register write: setup then access, only while the block is quiet
	task automatic write_allow(input logic value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_ALLOW_ADDR;
		pwdata  <= {{(APB_DATA_BITS-1){1'b0}}, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// wait until every predicted beat has come out, then let the pipe empty
	task automatic settle();
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] base_char(input int idx);
		case (idx)
			0: return "A";
			1: return "C";
			2: return "G";
			3: return "T";
			4: return "a";
			5: return "c";
			6: return "g";
			default: return "t";
		endcase
	endfunction

	function automatic logic [7:0] space_char(input int idx);
		case (idx)
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_LF;
			3: return CH_VT;
			4: return CH_FF;
			default: return CH_CR;
		endcase
	endfunction

	// mostly bases in streams closed by end of stream, with breaks, whitespace
	// and noise; heavy mode favours beats that each give a region record
	task automatic pick_item(input logic with_contigs, input logic heavy,
		output logic [1:0] kind, output logic [7:0] ch);
		int r;
		r    = $urandom_range(99);
		kind = REQ_CHAR;
		ch   = base_char($urandom_range(7));
		if (heavy) begin
			if (r < 40 && with_contigs)
				kind = REQ_CONTIG;
			else if (r < 70)
				ch = ($urandom_range(1) != 0) ? "N" : "n";
		end else if (r < 70) begin
			ch = base_char($urandom_range(7));
		end else if (r < 78) begin
			ch = 8'($urandom_range(255));
		end else if (r < 84) begin
			ch = ($urandom_range(1) != 0) ? "N" : "n";
		end else if (r < 89) begin
			ch = space_char($urandom_range(5));
		end else if (r < 92) begin
			ch = CH_GT;
		end else if (r < 96) begin
			if (with_contigs)
				kind = REQ_CONTIG;
		end else if (r < 99) begin
			kind = REQ_EOS;
		end else begin
			kind = REQ_SPARE;
			ch   = 8'($urandom_range(255));
		end
	endtask

	initial begin : stimulus
		logic [1:0] kind;
		logic [7:0] ch;

		arst_n         = 1'b0;
		push           = 1'b0;
		req_type       = REQ_CHAR;
		char_byte      = 8'h00;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = REG_ALLOW_ADDR;
		pwdata         = '0;
		feed_idle_pct  = 20;
		drain_idle_pct = 68;
		long_hold_req  = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		write_allow(1'b1);

		// directed: every base in both cases, then non-base characters
		// closing the run, the greater-than character as plain data
		for (int k = 0; k < 8; k++)
			offer_item(REQ_CHAR, base_char(k));
		offer_item(REQ_CHAR, "N");
		offer_item(REQ_CHAR, CH_GT);
		// whitespace gives nothing and does not move the position
		for (int k = 0; k < 6; k++)
			offer_item(REQ_CHAR, space_char(k));
		// byte extremes, the ignored request code
		offer_item(REQ_CHAR, 8'h00);
		offer_item(REQ_CHAR, 8'hff);
		offer_item(REQ_SPARE, 8'hff);
		// boundary with an open run, then with none (empty region)
		offer_item(REQ_CHAR, "g");
		offer_item(REQ_CONTIG, 8'h00);
		offer_item(REQ_CONTIG, 8'h00);
		// end of stream with a partial word, then an empty stream
		offer_item(REQ_EOS, 8'h00);
		offer_item(REQ_EOS, 8'h00);
		push <= 1'b0;
		settle();

		// sender idles lightly, receiver heavily, boundaries allowed
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			pick_item(1'b1, 1'b0, kind, ch);
			offer_item(kind, ch);
		end
		push <= 1'b0;
		settle();

		// the other way round, with boundaries forbidden and so never sent
		feed_idle_pct  <= 68;
		drain_idle_pct <= 20;
		write_allow(1'b0);
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			pick_item(1'b0, 1'b0, kind, ch);
			offer_item(kind, ch);
		end
		push <= 1'b0;
		settle();

		// no idling; the receiver holds off while region-heavy beats pile up
		feed_idle_pct  <= 0;
		drain_idle_pct <= 0;
		write_allow(1'b1);
		long_hold_req <= 1'b1;
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			pick_item(1'b1, n < HEAVY_ITEMS, kind, ch);
			offer_item(kind, ch);
		end
		push <= 1'b0;
		settle();

		// a forbidden boundary raises the error and halts the block for good,
		// so this comes last; everything after it is swallowed
		write_allow(1'b0);
		offer_item(REQ_CHAR, "A");
		offer_item(REQ_CHAR, "c");
		offer_item(REQ_CONTIG, 8'h00);
		offer_item(REQ_CHAR, "G");
		offer_item(REQ_CONTIG, 8'h00);
		offer_item(REQ_EOS, 8'h00);
		offer_item(REQ_SPARE, 8'h5a);
		push <= 1'b0;
		settle();

		@(negedge clk);
		if (fail_count == 0)
			$display("tb_dna_two_bit_squash_encoder_core passed");
		else
			$display("tb_dna_two_bit_squash_encoder_core failed");
		$finish;
	end

endmodule

>>> dna_two_bit_squash_encoder_core.f
src/dtbs_pkg.sv
src/dtbs_front.sv
src/dtbs_opq.sv
src/dtbs_back.sv
src/dna_two_bit_squash_encoder_core.sv
test/dtbs_core_checker.sv
test/tb_dna_two_bit_squash_encoder_core.sv
